// ----- design/upd_pkg.sv -----
// shared types, character constants and hex helpers for the url percent decoder
// no dependencies; used by upd_core and url_percent_decoder_unit
`default_nettype none

package upd_pkg;

  localparam logic [7:0] CharNul     = 8'h00;
  localparam logic [7:0] CharPercent = 8'h25;
  localparam logic [7:0] CharPlus    = 8'h2B;
  localparam logic [7:0] CharSpace   = 8'h20;
  localparam logic [7:0] CharZero    = 8'h30;
  localparam logic [7:0] UpperGap    = 8'd7;
  localparam logic [7:0] LowerGap    = 8'd32;

  // one decoded result
  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       run_last;
    logic       msg_end;
  } res_t;

  // everything one input byte produces
  typedef struct packed {
    logic [1:0] count;
    res_t       r0;
    res_t       r1;
  } dec_t;

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
           (c >= 8'h61 && c <= 8'h66);
  endfunction

  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    logic [7:0] v;
    v = c - CharZero;
    if (c >= 8'h41) v = v - UpperGap;
    if (c >= 8'h61) v = v - LowerGap;
    return v[3:0];
  endfunction

endpackage

`default_nettype wire

// ----- design/url_percent_decoder_unit.sv -----
// top level of the url percent decoder: input register, decode core, result buffer
// depends on upd_pkg and upd_core
`default_nettype none

// Decodes a form-urlencoded byte stream, one byte per transfer on the slave
// side. '+' becomes a space, '%' and two hex digits (either case) become one
// byte, a broken percent sequence drops the '%' and emits a held digit as
// itself, and a zero byte silences the rest of the message up to the byte
// marked tlast. Each input byte gives zero, one or two results; the byte
// marked tlast always gives at least one, and its final result carries
// m_axis_tlast (end of message). Rate: one byte per cycle while the result
// buffer has room. The input register feeds the decode core, whose results
// land in a two-entry result buffer; a byte that yields two results takes an
// extra output slot, which the buffer absorbs so the input keeps flowing
// unless the consumer stalls.
module url_percent_decoder_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // slave side
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] in_byte
  input  wire logic        s_axis_tlast_i,   // in_last
  // master side
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [15:0]      m_axis_tdata_o,   // [7:0] out_byte, [8] run_last, rest zero
  output logic             m_axis_tuser_o,   // out_valid
  output logic             m_axis_tlast_o    // message_end
);

  // input register
  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;

  // result buffer, entry 0 is the head
  upd_pkg::res_t buf0_q, buf0_d;
  upd_pkg::res_t buf1_q, buf1_d;
  logic [1:0]    cnt_q, cnt_d;

  upd_pkg::dec_t dec;
  logic          pop;
  logic          fire;
  logic [1:0]    cnt_pop;
  logic [2:0]    room;

  upd_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .byte_i (in_byte_q),
    .last_i (in_last_q),
    .fire_i (fire),
    .dec_o  (dec)
  );

  assign m_axis_tvalid_o = (cnt_q != 2'd0);
  assign pop             = m_axis_tvalid_o && m_axis_tready_i;
  assign cnt_pop         = cnt_q - {1'b0, pop};
  assign room            = 3'd2 - {1'b0, cnt_pop};

  // decoded byte moves on only when all its results fit in the buffer
  assign fire            = in_vld_q && ({1'b0, dec.count} <= room);
  assign s_axis_tready_o = !in_vld_q || fire;

  always_comb begin
    buf0_d = pop ? buf1_q : buf0_q;
    buf1_d = buf1_q;
    cnt_d  = cnt_pop;
    if (fire && dec.count != 2'd0) begin
      if (cnt_pop == 2'd0) begin
        buf0_d = dec.r0;
        buf1_d = dec.r1;
      end else begin
        buf1_d = dec.r0;
      end
      cnt_d = cnt_pop + dec.count;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (s_axis_tready_o) begin
        in_vld_q <= s_axis_tvalid_i;
      end
      cnt_q <= cnt_d;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_byte_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
    buf0_q <= buf0_d;
    buf1_q <= buf1_d;
  end

  assign m_axis_tdata_o = {7'b0, buf0_q.run_last, buf0_q.data};
  assign m_axis_tuser_o = buf0_q.valid;
  assign m_axis_tlast_o = buf0_q.msg_end;

endmodule

`default_nettype wire

// ----- design/upd_core.sv -----
// decode state machine: phase and held digit, plus the per-byte result logic
// depends on upd_pkg
`default_nettype none

module upd_core (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic [7:0]    byte_i,
  input  wire logic          last_i,
  input  wire logic          fire_i,
  output upd_pkg::dec_t      dec_o
);

  typedef enum logic [1:0] {
    PhNormal  = 2'd0,
    PhPercent = 2'd1,
    PhHold    = 2'd2,
    PhStop    = 2'd3
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [7:0] held_q, held_d;

  always_comb begin
    logic          p_valid;
    logic [7:0]    p_byte;
    phase_e        p_phase;
    logic          a_valid;
    logic [7:0]    a_byte;
    logic          b_valid;
    logic          use_plain;
    logic [1:0]    cnt;
    upd_pkg::res_t r0;
    upd_pkg::res_t r1;

    // byte handled as in the normal phase
    p_valid = 1'b0;
    p_byte  = byte_i;
    p_phase = PhNormal;
    priority if (byte_i == upd_pkg::CharNul) begin
      p_phase = PhStop;
    end else if (byte_i == upd_pkg::CharPercent) begin
      p_phase = PhPercent;
    end else if (byte_i == upd_pkg::CharPlus) begin
      p_valid = 1'b1;
      p_byte  = upd_pkg::CharSpace;
    end else begin
      p_valid = 1'b1;
    end

    a_valid   = 1'b0;
    a_byte    = held_q;
    use_plain = 1'b0;
    b_valid   = 1'b0;
    phase_d   = phase_q;
    held_d    = held_q;

    unique case (phase_q)
      PhNormal: begin
        use_plain = 1'b1;
      end
      PhPercent: begin
        if (upd_pkg::is_hex(byte_i)) begin
          held_d  = byte_i;
          phase_d = PhHold;
          a_valid = last_i;
          a_byte  = byte_i;
        end else begin
          use_plain = 1'b1;
        end
      end
      PhHold: begin
        a_valid = 1'b1;
        if (upd_pkg::is_hex(byte_i)) begin
          a_byte  = {upd_pkg::hex_nibble(held_q), upd_pkg::hex_nibble(byte_i)};
          phase_d = PhNormal;
        end else begin
          use_plain = 1'b1;
        end
      end
      PhStop: begin
      end
      default: begin
      end
    endcase

    if (use_plain) begin
      phase_d = p_phase;
      b_valid = p_valid;
    end
    if (last_i) begin
      phase_d = PhNormal;
      held_d  = '0;
    end

    r0  = '0;
    r1  = '0;
    cnt = {1'b0, a_valid} + {1'b0, b_valid};
    if (a_valid) begin
      r0.data  = a_byte;
      r0.valid = 1'b1;
      r1.data  = p_byte;
      r1.valid = b_valid;
    end else if (b_valid) begin
      r0.data  = p_byte;
      r0.valid = 1'b1;
    end
    // end of message with nothing decoded still yields a marker result
    if (last_i && cnt == 2'd0) begin
      cnt = 2'd1;
    end
    if (cnt == 2'd2) begin
      r1.run_last = 1'b1;
      r1.msg_end  = last_i;
    end else if (cnt == 2'd1) begin
      r0.run_last = 1'b1;
      r0.msg_end  = last_i;
    end

    dec_o.count = cnt;
    dec_o.r0    = r0;
    dec_o.r1    = r1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhNormal;
      held_q  <= '0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      held_q  <= held_d;
    end
  end

endmodule

`default_nettype wire

// ----- design/upd_chk.sv -----
// port-level checker for url_percent_decoder_unit, with its bind statement
// no package dependencies
`default_nettype none

module upd_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [15:0] m_axis_tdata_o,
  input wire logic        m_axis_tuser_o,
  input wire logic        m_axis_tlast_o
);

  // nothing leaves while reset holds
  a_quiet_in_reset: assert property (@(posedge clk_i)
    !rst_ni |-> !m_axis_tvalid_o)
    else $error("result transfer offered during reset");

  // end of message is always the last result of its input byte
  a_end_is_run_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tlast_o |-> m_axis_tdata_o[8])
    else $error("message end without run_last");

  // a result without a decoded byte only marks end of message, with zero data
  a_empty_is_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |->
      m_axis_tlast_o && m_axis_tdata_o[7:0] == 8'h00)
    else $error("empty result that is not an end marker");

  // stalled result holds
  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o) &&
      $stable(m_axis_tlast_o))
    else $error("result changed while stalled");

endmodule

bind url_percent_decoder_unit upd_chk u_upd_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

`default_nettype wire

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// self-checking bench for url_percent_decoder_unit: a directed table and then random messages
// depends on upd_pkg and the decoder rtl; results are checked against a predictor kept in here

module testbench;

  // where the predictor stands within a message
  typedef enum logic [1:0] {
    PhNormal,
    PhPercent,
    PhHold,
    PhStop
  } dec_phase_e;

  // one row of the directed table; typed rows carry their own answer
  typedef struct {
    logic [7:0]     b;
    bit             last;
    bit             typed;
    int             n;
    upd_pkg::res_t  r0;
  } stim_row_t;

  localparam int RandomBytes = 1200;
  localparam int IdlePct     = 21;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tlast = 1'b0;
  logic        m_tready = 1'b0;
  wire         s_axis_tready_o;
  wire         m_axis_tvalid_o;
  wire  [15:0] m_axis_tdata_o;    // [7:0] out_byte, [8] run_last, rest zero
  wire         m_axis_tuser_o;    // out_valid
  wire         m_axis_tlast_o;    // message_end

  // predictor state and the queue of decoded results still to come
  dec_phase_e     pred_phase = PhNormal;
  logic [7:0]     pred_held = 8'h00;
  upd_pkg::res_t  step_res[$];
  upd_pkg::res_t  decoded_q[$];

  stim_row_t      dir_tab[$];
  logic [7:0]     msg_bytes[$];
  bit             calm = 1'b0;
  bit             drained_mid = 1'b0;
  int             fail_count = 0;
  int             bytes_live = 0;
  int             bytes_sent = 0;
  int             messages = 0;
  int             pairs = 0;
  int             results_seen = 0;
  upd_pkg::res_t  got;
  upd_pkg::res_t  want;

  url_percent_decoder_unit u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // hard limit on the whole run
  initial begin
    #2_000_000;
    $display("FAIL url_percent_decoder_unit");
    $finish;
  end

  function automatic upd_pkg::res_t mk_res(input logic [7:0] d, input logic v,
                                           input logic rl, input logic me);
    upd_pkg::res_t r;
    r.data     = d;
    r.valid    = v;
    r.run_last = rl;
    r.msg_end  = me;
    return r;
  endfunction

  function automatic bit hex_digit(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
  endfunction

  // value of a hex digit, only ever called on one
  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    if (c <= "9") begin
      v = c - "0";
    end else if (c <= "F") begin
      v = c - "A" + 8'd10;
    end else begin
      v = c - "a" + 8'd10;
    end
    return v[3:0];
  endfunction

  function automatic void push_char(input logic [7:0] b);
    step_res.push_back(mk_res(b, 1'b1, 1'b0, 1'b0));
  endfunction

  // a byte seen outside any percent sequence
  function automatic void plain_char(input logic [7:0] b);
    if (b == upd_pkg::CharNul) begin
      pred_phase = PhStop;
    end else if (b == upd_pkg::CharPercent) begin
      pred_phase = PhPercent;
    end else if (b == upd_pkg::CharPlus) begin
      push_char(upd_pkg::CharSpace);
      pred_phase = PhNormal;
    end else begin
      push_char(b);
      pred_phase = PhNormal;
    end
  endfunction

  // works out what one accepted byte yields, left in step_res
  function automatic void decode_step(input logic [7:0] b, input bit last);
    upd_pkg::res_t r;
    step_res.delete();
    if (pred_phase != PhStop) bytes_live++;
    case (pred_phase)
      PhNormal: begin
        plain_char(b);
      end
      PhPercent: begin
        if (hex_digit(b)) begin
          pred_held  = b;
          pred_phase = PhHold;
          // message cut after one digit: the digit stands for itself
          if (last) push_char(b);
        end else begin
          plain_char(b);
        end
      end
      PhHold: begin
        if (hex_digit(b)) begin
          push_char({hex_val(pred_held), hex_val(b)});
          pred_phase = PhNormal;
        end else begin
          // broken sequence: held digit out first, then this byte as usual
          push_char(pred_held);
          plain_char(b);
        end
      end
      default: begin
      end
    endcase
    if (last) begin
      if (step_res.size() == 0) step_res.push_back(mk_res(8'h00, 1'b0, 1'b0, 1'b0));
      r = step_res.pop_back();
      r.msg_end = 1'b1;
      step_res.push_back(r);
      pred_phase = PhNormal;
      pred_held  = 8'h00;
      messages++;
    end
    if (step_res.size() > 0) begin
      r = step_res.pop_back();
      r.run_last = 1'b1;
      step_res.push_back(r);
    end
    if (step_res.size() == 2) pairs++;
  endfunction

  task automatic report_mismatch(input string what, input int got_v, input int want_v);
    $display("mismatch at %0t ns: %s got %0h expected %0h", $time, what, got_v, want_v);
    fail_count++;
  endtask

  // one transfer on the slave side, with random idle cycles ahead of it
  task automatic send_byte(input logic [7:0] b, input bit last);
    while (!calm && $urandom_range(0, 99) < IdlePct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    bytes_sent++;
    decode_step(b, last);
  endtask

  // hold the input back until every pending result has come out
  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(posedge clk_i); while (decoded_q.size() != 0);
  endtask

  function automatic logic [7:0] rand_hex();
    int idx;
    idx = $urandom_range(0, 21);
    if (idx < 10) return 8'("0" + idx);
    if (idx < 16) return 8'("a" + idx - 10);
    return 8'("A" + idx - 16);
  endfunction

  function automatic logic [7:0] rand_nonhex();
    logic [7:0] c;
    c = 8'($urandom_range(1, 255));
    while (hex_digit(c)) c = 8'($urandom_range(1, 255));
    return c;
  endfunction

  // builds one message, mostly well-formed tokens with some broken ones and noise
  function automatic void build_message();
    int ntok;
    int pick;
    msg_bytes.delete();
    ntok = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(1, 10);
    for (int t = 0; t < ntok; t++) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        msg_bytes.push_back(8'($urandom_range(1, 255)));
      end else if (pick < 40) begin
        msg_bytes.push_back(upd_pkg::CharPlus);
      end else if (pick < 75) begin
        msg_bytes.push_back(upd_pkg::CharPercent);
        msg_bytes.push_back(rand_hex());
        msg_bytes.push_back(rand_hex());
      end else if (pick < 83) begin
        msg_bytes.push_back(upd_pkg::CharPercent);
        msg_bytes.push_back(rand_hex());
        msg_bytes.push_back(rand_nonhex());
      end else if (pick < 89) begin
        msg_bytes.push_back(upd_pkg::CharPercent);
        msg_bytes.push_back(rand_nonhex());
      end else if (pick < 93) begin
        msg_bytes.push_back(upd_pkg::CharPercent);
      end else if (pick < 96) begin
        // percent and one digit, a cut sequence when it ends the message
        msg_bytes.push_back(upd_pkg::CharPercent);
        msg_bytes.push_back(rand_hex());
      end else begin
        msg_bytes.push_back(upd_pkg::CharNul);
      end
    end
  endfunction

  // consumer side: random stalls except during the calm stretch
  always @(posedge clk_i) begin
    m_tready <= calm ? 1'b1 : ($urandom_range(0, 99) >= IdlePct);
  end

  // every result transfer is compared with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_tready) begin
      got = mk_res(m_axis_tdata_o[7:0], m_axis_tuser_o, m_axis_tdata_o[8], m_axis_tlast_o);
      if (decoded_q.size() == 0) begin
        report_mismatch("result with nothing pending", int'(got), 0);
      end else begin
        want = decoded_q.pop_front();
        results_seen++;
        if (got.data != want.data) report_mismatch("out_byte", got.data, want.data);
        if (got.valid != want.valid) report_mismatch("out_valid", got.valid, want.valid);
        if (got.run_last != want.run_last) begin
          report_mismatch("run_last", got.run_last, want.run_last);
        end
        if (got.msg_end != want.msg_end) begin
          report_mismatch("message_end", got.msg_end, want.msg_end);
        end
        if (m_axis_tdata_o[15:9] != 7'd0) begin
          report_mismatch("tdata padding", m_axis_tdata_o[15:9], 0);
        end
      end
    end
  end

  initial begin
    // directed table: untyped rows go through the predictor, typed rows carry their answer
    dir_tab.push_back('{"A",                  0, 1, 1, mk_res("A", 1, 1, 0)});
    dir_tab.push_back('{upd_pkg::CharPlus,    0, 1, 1, mk_res(upd_pkg::CharSpace, 1, 1, 0)});
    dir_tab.push_back('{upd_pkg::CharPercent, 0, 1, 0, mk_res(0, 0, 0, 0)});
    dir_tab.push_back('{"4",                  0, 0, 0, mk_res(0, 0, 0, 0)});
    dir_tab.push_back('{"1",                  0, 0, 0, mk_res(0, 0, 0, 0)});
    dir_tab.push_back('{upd_pkg::CharPercent, 0, 0, 0, mk_res(0, 0, 0, 0)});
    dir_tab.push_back('{"f",                  0, 0, 0, mk_res(0, 0, 0, 0)});
    dir_tab.push_back('{"F",                  0, 0, 0, mk_res(0, 0, 0, 0)});
    // broken sequence, two results from one byte
    dir_tab.push_back('{upd_pkg::CharPercent, 0, 0, 0, mk_res(0, 0, 0, 0)});
    dir_tab.push_back('{"a",                  0, 0, 0, mk_res(0, 0, 0, 0)});
    dir_tab.push_back('{"z",                  0, 0, 0, mk_res(0, 0, 0, 0)});
    // percent after percent, then a full sequence
    dir_tab.push_back('{upd_pkg::CharPercent, 0, 0, 0, mk_res(0, 0, 0, 0)});
    dir_tab.push_back('{upd_pkg::CharPercent, 0, 0, 0, mk_res(0, 0, 0, 0)});
    dir_tab.push_back('{"7",                  0, 0, 0, mk_res(0, 0, 0, 0)});
    dir_tab.push_back('{"e",                  0, 0, 0, mk_res(0, 0, 0, 0)});
    // zero byte silences the rest of the message
    dir_tab.push_back('{upd_pkg::CharNul,     0, 1, 0, mk_res(0, 0, 0, 0)});
    dir_tab.push_back('{"x",                  0, 1, 0, mk_res(0, 0, 0, 0)});
    dir_tab.push_back('{"y",                  1, 1, 1, mk_res(0, 0, 1, 1)});
    // message ending right after a percent
    dir_tab.push_back('{upd_pkg::CharPercent, 1, 1, 1, mk_res(0, 0, 1, 1)});
    // message ending with one digit held
    dir_tab.push_back('{upd_pkg::CharPercent, 0, 0, 0, mk_res(0, 0, 0, 0)});
    dir_tab.push_back('{"3",                  1, 0, 0, mk_res(0, 0, 0, 0)});
    dir_tab.push_back('{upd_pkg::CharPercent, 0, 0, 0, mk_res(0, 0, 0, 0)});
    dir_tab.push_back('{"9",                  0, 0, 0, mk_res(0, 0, 0, 0)});
    dir_tab.push_back('{upd_pkg::CharPlus,    1, 0, 0, mk_res(0, 0, 0, 0)});
    dir_tab.push_back('{8'hFF,                1, 1, 1, mk_res(8'hFF, 1, 1, 1)});

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      send_byte(dir_tab[i].b, dir_tab[i].last);
      if (dir_tab[i].typed) begin
        if (dir_tab[i].n > 0) decoded_q.push_back(dir_tab[i].r0);
      end else begin
        foreach (step_res[k]) decoded_q.push_back(step_res[k]);
      end
    end
    drain_results();

    // random messages, with a calm stretch and a full drain half way
    while (bytes_sent < RandomBytes + dir_tab.size()) begin
      calm <= (bytes_live >= 400 && bytes_live < 650);
      if (!drained_mid && bytes_live >= 700) begin
        drain_results();
        drained_mid = 1'b1;
      end
      build_message();
      foreach (msg_bytes[k]) begin
        send_byte(msg_bytes[k], k == msg_bytes.size() - 1);
        foreach (step_res[j]) decoded_q.push_back(step_res[j]);
      end
    end
    drain_results();
    repeat (10) @(posedge clk_i);

    if (decoded_q.size() != 0) report_mismatch("results never arrived", decoded_q.size(), 0);
    $display("covered %0d bytes (%0d live) over %0d messages, %0d results checked",
             bytes_sent, bytes_live, messages, results_seen);
    $display("%0d bytes gave two results, %0d mismatches", pairs, fail_count);
    if (fail_count == 0) begin
      $display("PASS url_percent_decoder_unit");
    end else begin
      $display("FAIL url_percent_decoder_unit");
    end
    $finish;
  end

endmodule
